// File: design/typed_coordinate_frame_parser_macros.svh
// assertion macros used by the coordinate frame parser top level
`ifndef TYPED_COORDINATE_FRAME_PARSER_MACROS_SVH
`define TYPED_COORDINATE_FRAME_PARSER_MACROS_SVH

// same-cycle implication on clk, held off during reset
`define TCFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, held off during reset
`define TCFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tcfp_pkg.sv
// shared types and constants of the coordinate frame parser
package tcfp_pkg;

	localparam int BYTE_W     = 8;
	localparam int KIND_W     = 2;
	localparam int IDX_W      = 4;
	localparam int COORD_W    = 16;
	localparam int FRAME_W    = 16;
	localparam int PAIR_CNT_W = 5;

	localparam int CENTER_PAIRS_DEF = 9;
	localparam int PIECE_PAIRS_DEF  = 5;

	// received byte codes
	localparam logic [BYTE_W-1:0] BYTE_HEADER = 8'h2C;
	localparam logic [BYTE_W-1:0] BYTE_CENTRE = 8'h12;
	localparam logic [BYTE_W-1:0] BYTE_BLACK  = 8'h13;
	localparam logic [BYTE_W-1:0] BYTE_WHITE  = 8'h14;
	localparam logic [BYTE_W-1:0] BYTE_END    = 8'h5B;

	// frame kind codes on the output
	localparam logic [KIND_W-1:0] KIND_CENTRE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WHITE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BLACK  = 2'd2;

	// completed frame handed from parser to emitter
	typedef struct packed {
		logic                  valid;
		logic [KIND_W-1:0]     kind;
		logic [PAIR_CNT_W-1:0] pairs;
		logic [FRAME_W-1:0]    frame;
	} tcfp_start_t;

endpackage

// File: design/tcfp_ifs.sv
// valid/ready channel interfaces for byte input and pair output
interface tcfp_in_if;
	logic                         valid;
	logic                         ready;
	logic [tcfp_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tcfp_out_if;
	logic                                valid;
	logic                                ready;
	logic [tcfp_pkg::KIND_W-1:0]         frame_kind;
	logic [tcfp_pkg::IDX_W-1:0]          pair_index;
	logic signed [tcfp_pkg::COORD_W-1:0] coord_x;
	logic signed [tcfp_pkg::COORD_W-1:0] coord_y;
	logic [tcfp_pkg::FRAME_W-1:0]        frame_number;
	logic                                last_pair;

	modport source (output valid, output frame_kind, output pair_index, output coord_x,
		output coord_y, output frame_number, output last_pair, input ready);
	modport sink (input valid, input frame_kind, input pair_index, input coord_x,
		input coord_y, input frame_number, input last_pair, output ready);
endinterface

// File: design/tcfp_ram.sv
// generic single-write, single-read ram with registered read data
module tcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/tcfp_parser.sv
// byte parser: header, kind and payload phases, store writes, frame completion
module tcfp_parser #(
	parameter int CENTER_PAIRS = tcfp_pkg::CENTER_PAIRS_DEF,
	parameter int PIECE_PAIRS  = tcfp_pkg::PIECE_PAIRS_DEF,
	parameter int DEPTH        = 4 * ((CENTER_PAIRS > PIECE_PAIRS) ? CENTER_PAIRS : PIECE_PAIRS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [tcfp_pkg::BYTE_W-1:0] in_byte,
	input  logic                        busy,
	output logic                        in_ready,
	output logic                        wr_en,
	output logic [$clog2(DEPTH)-1:0]    wr_addr,
	output logic [tcfp_pkg::BYTE_W-1:0] wr_data,
	output tcfp_pkg::tcfp_start_t       start
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] CENTER_BYTES = CW'(4 * CENTER_PAIRS);
	localparam logic [CW-1:0] PIECE_BYTES  = CW'(4 * PIECE_PAIRS);
	localparam logic [CW-1:0] DEPTH_C      = CW'(DEPTH);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_KIND    = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]                    phase_q, phase_n;
	logic [tcfp_pkg::KIND_W-1:0]   kind_q, kind_n;
	logic [CW-1:0]                 count_q, count_n;
	logic [tcfp_pkg::FRAME_W-1:0]  frames_q;
	logic [CW-1:0]                 need;
	logic                          store_c;
	logic                          accept;
	logic                          complete;

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;

	// next phase, kind and count for the byte on the input
	always_comb begin
		phase_n = phase_q;
		kind_n  = kind_q;
		count_n = count_q;
		store_c = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (in_byte == tcfp_pkg::BYTE_HEADER) begin
					phase_n = PH_KIND;
				end else begin
					count_n = '0;
				end
			end
			PH_KIND: begin
				if (in_byte == tcfp_pkg::BYTE_CENTRE) begin
					kind_n = tcfp_pkg::KIND_CENTRE;
				end else if (in_byte == tcfp_pkg::BYTE_BLACK) begin
					kind_n = tcfp_pkg::KIND_BLACK;
				end else if (in_byte == tcfp_pkg::BYTE_WHITE) begin
					kind_n = tcfp_pkg::KIND_WHITE;
				end
				phase_n = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (in_byte == tcfp_pkg::BYTE_END) begin
					phase_n = PH_IDLE;
				end else if (count_q < DEPTH_C) begin
					store_c = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				count_n = '0;
			end
		endcase
	end

	// size check against the kind in force after this byte
	assign need     = (kind_n == tcfp_pkg::KIND_CENTRE) ? CENTER_BYTES : PIECE_BYTES;
	assign complete = (count_n >= need);

	// store write at the current fill position
	assign wr_en   = accept && store_c;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = in_byte;

	// completed frame goes to the emitter in the accepting cycle
	assign start.valid = accept && complete;
	assign start.kind  = kind_n;
	assign start.pairs = tcfp_pkg::PAIR_CNT_W'(count_n >> 2);
	assign start.frame = frames_q + 1'b1;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			kind_q   <= tcfp_pkg::KIND_CENTRE;
			count_q  <= '0;
			frames_q <= '0;
		end else if (accept) begin
			kind_q <= kind_n;
			if (complete) begin
				phase_q  <= PH_IDLE;
				count_q  <= '0;
				frames_q <= frames_q + 1'b1;
			end else begin
				phase_q <= phase_n;
				count_q <= count_n;
			end
		end
	end

endmodule

// File: design/tcfp_emitter.sv
// pair emitter: reads the store one byte a cycle in its read state into a shift register
module tcfp_emitter #(
	parameter int DEPTH = 36
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcfp_pkg::tcfp_start_t       start,
	output logic                        busy,
	output logic                        rd_en,
	output logic [$clog2(DEPTH)-1:0]    rd_addr,
	input  logic [tcfp_pkg::BYTE_W-1:0] rd_data,
	tcfp_out_if.source                  out_ch
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = 3 * tcfp_pkg::BYTE_W;

	localparam logic [1:0] EM_IDLE = 2'd0;
	localparam logic [1:0] EM_READ = 2'd1;
	localparam logic [1:0] EM_SHOW = 2'd2;

	localparam logic [2:0] CNT_LAST = 3'd4;

	logic [1:0]                          state_q;
	logic [2:0]                          cnt_q;
	logic [tcfp_pkg::PAIR_CNT_W-1:0]     pair_q;
	logic [tcfp_pkg::PAIR_CNT_W-1:0]     pairs_q;
	logic [tcfp_pkg::PAIR_CNT_W-1:0]     pair_inc;
	logic [SW-1:0]                       shreg_q;
	logic [tcfp_pkg::KIND_W-1:0]         kind_q;
	logic [tcfp_pkg::FRAME_W-1:0]        frame_q;
	logic signed [tcfp_pkg::COORD_W-1:0] x_q;
	logic signed [tcfp_pkg::COORD_W-1:0] y_q;
	logic [tcfp_pkg::IDX_W-1:0]          idx_q;
	logic                                last_q;

	assign busy     = (state_q != EM_IDLE);
	assign pair_inc = pair_q + 1'b1;

	// one store read per cycle for the four bytes of a pair
	assign rd_en   = (state_q == EM_READ) && (cnt_q != CNT_LAST);
	assign rd_addr = AW'({pair_q, cnt_q[1:0]});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			cnt_q   <= '0;
			pair_q  <= '0;
			pairs_q <= '0;
		end else begin
			case (state_q)
				EM_IDLE: begin
					if (start.valid) begin
						pairs_q <= start.pairs;
						pair_q  <= '0;
						cnt_q   <= '0;
						state_q <= EM_READ;
					end
				end
				EM_READ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= EM_SHOW;
					end
				end
				EM_SHOW: begin
					if (out_ch.ready) begin
						if (pair_inc == pairs_q) begin
							state_q <= EM_IDLE;
						end else begin
							pair_q  <= pair_inc;
							cnt_q   <= '0;
							state_q <= EM_READ;
						end
					end
				end
				default: begin
					state_q <= EM_IDLE;
				end
			endcase
		end
	end

	// byte shift register and output item
	always_ff @(posedge clk) begin
		if ((state_q == EM_IDLE) && start.valid) begin
			kind_q  <= start.kind;
			frame_q <= start.frame;
		end
		if ((state_q == EM_READ) && (cnt_q != '0)) begin
			if (cnt_q == CNT_LAST) begin
				x_q    <= shreg_q[SW-1:tcfp_pkg::BYTE_W];
				y_q    <= {shreg_q[tcfp_pkg::BYTE_W-1:0], rd_data};
				idx_q  <= pair_q[tcfp_pkg::IDX_W-1:0];
				last_q <= (pair_inc == pairs_q);
			end else begin
				shreg_q <= {shreg_q[SW-tcfp_pkg::BYTE_W-1:0], rd_data};
			end
		end
	end

	assign out_ch.valid        = (state_q == EM_SHOW);
	assign out_ch.frame_kind   = kind_q;
	assign out_ch.pair_index   = idx_q;
	assign out_ch.coord_x      = x_q;
	assign out_ch.coord_y      = y_q;
	assign out_ch.frame_number = frame_q;
	assign out_ch.last_pair    = last_q;

endmodule

// File: design/typed_coordinate_frame_parser.sv
// top level of the typed coordinate frame parser
// Takes one received byte per cycle while no frame is being emitted. When a byte completes
// a frame, the input holds off ready and the block emits count/4 coordinate pairs, each one
// built from four store bytes read one per cycle through the store's single read port:
// each pair is read and shifted in the read state and then shown until the output takes
// it, and the reads of the next pair start only after that.
`include "typed_coordinate_frame_parser_macros.svh"

module typed_coordinate_frame_parser #(
	parameter int CENTER_PAIRS = tcfp_pkg::CENTER_PAIRS_DEF,
	parameter int PIECE_PAIRS  = tcfp_pkg::PIECE_PAIRS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tcfp_in_if.sink    in_ch,
	tcfp_out_if.source out_ch
);

	localparam int DEPTH = 4 * ((CENTER_PAIRS > PIECE_PAIRS) ? CENTER_PAIRS : PIECE_PAIRS);
	localparam int AW    = $clog2(DEPTH);

	logic                        busy;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [tcfp_pkg::BYTE_W-1:0] wr_data;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [tcfp_pkg::BYTE_W-1:0] rd_data;
	tcfp_pkg::tcfp_start_t       start;
	logic                        take_mid;
	logic                        take_last;

	// byte parser
	tcfp_parser #(
		.CENTER_PAIRS(CENTER_PAIRS),
		.PIECE_PAIRS (PIECE_PAIRS),
		.DEPTH       (DEPTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_byte (in_ch.rx_byte),
		.busy    (busy),
		.in_ready(in_ch.ready),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.start   (start)
	);

	// payload store
	tcfp_ram #(
		.WIDTH(tcfp_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// pair emitter
	tcfp_emitter #(
		.DEPTH(DEPTH)
	) u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.out_ch (out_ch)
	);

	// pair items taken, split by last flag
	assign take_mid  = out_ch.valid && out_ch.ready && !out_ch.last_pair;
	assign take_last = out_ch.valid && out_ch.ready && out_ch.last_pair;

	// checks on parser and emitter cooperation
	`TCFP_ASSERT_NOW(a_no_input_while_shown, out_ch.valid, !in_ch.ready, "input open during emit")
	`TCFP_ASSERT_NEXT(a_start_taken, start.valid, busy, "completed frame not picked up")
	`TCFP_ASSERT_NEXT(a_more_pairs, take_mid, busy && !out_ch.valid, "pair sequence cut short")
	`TCFP_ASSERT_NEXT(a_frame_done, take_last, !out_ch.valid && !busy, "emit ran past last pair")

endmodule
